@@ sv/bis_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package bis_pkg;

  // Fixed widths of the channel fields and configuration registers.
  localparam int COUNT_W  = 7;
  localparam int INDEX_W  = 6;
  localparam int PIXIN_W  = 16;
  localparam int COORD_W  = 16;
  localparam int SAMPLE_W = 16;
  localparam int CFG_IDX_W = 1;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd64;
  localparam logic [COUNT_W-1:0] COUNT_MIN   = 7'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_IN_USE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_IN_USE = 1'b1;

  // Operation codes of an input word.
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // Neighbor selects around the floor cell.
  localparam logic [1:0] NB_F11 = 2'd0;
  localparam logic [1:0] NB_F21 = 2'd1;
  localparam logic [1:0] NB_F12 = 2'd2;
  localparam logic [1:0] NB_F22 = 2'd3;

  typedef struct packed {
    logic       capture;
    logic       wr;
    logic       prep;
    logic       rd;
    logic [1:0] rd_sel;
    logic       cap;
    logic [1:0] cap_sel;
    logic       mul_a;
    logic       mul_b;
    logic       load_out;
  } bis_cmd_t;

  typedef struct packed {
    logic wr_ok;
    logic in_image;
  } bis_status_t;

endpackage
`default_nettype wire

@@ sv/bis_req_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
interface bis_req_if;
  logic                               valid;
  logic                               ready;
  logic                               func;
  logic        [bis_pkg::INDEX_W-1:0] pixel_row;
  logic        [bis_pkg::INDEX_W-1:0] pixel_col;
  logic        [bis_pkg::PIXIN_W-1:0] pixel_value;
  logic signed [bis_pkg::COORD_W-1:0] query_row;
  logic signed [bis_pkg::COORD_W-1:0] query_col;

  modport source (
    output valid, func, pixel_row, pixel_col, pixel_value, query_row, query_col,
    input  ready
  );
  modport sink (
    input  valid, func, pixel_row, pixel_col, pixel_value, query_row, query_col,
    output ready
  );
endinterface
`default_nettype wire

@@ sv/bis_rsp_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
interface bis_rsp_if;
  logic                                valid;
  logic                                ready;
  logic                                inside_res;
  logic [bis_pkg::SAMPLE_W-1:0]        sample;

  modport source (
    output valid, inside_res, sample,
    input  ready
  );
  modport sink (
    input  valid, inside_res, sample,
    output ready
  );
endinterface
`default_nettype wire

@@ sv/bis_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
module bis_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;
endmodule
`default_nettype wire

@@ sv/bis_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
module bis_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_func_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  bis_pkg::bis_status_t status_i,
  output bis_pkg::bis_cmd_t    cmd_o
);
  import bis_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_WRITE,
    S_ADDR,
    S_RD0,
    S_RD1,
    S_RD2,
    S_RD3,
    S_CAP,
    S_MULA,
    S_MULB,
    S_OUT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   in_acc;
  logic   out_free;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          cmd_o.capture = 1'b1;
          state_d = (in_func_i == FUNC_QUERY) ? S_ADDR : S_WRITE;
        end
      end
      S_WRITE: begin
        cmd_o.wr = status_i.wr_ok;
        state_d  = S_IDLE;
      end
      S_ADDR: begin
        cmd_o.prep = 1'b1;
        state_d    = S_RD0;
      end
      S_RD0: begin
        // An outside query skips the reads and answers zero.
        if (status_i.in_image) begin
          cmd_o.rd     = 1'b1;
          cmd_o.rd_sel = NB_F11;
          state_d      = S_RD1;
        end else begin
          state_d = S_OUT;
        end
      end
      S_RD1: begin
        cmd_o.rd      = 1'b1;
        cmd_o.rd_sel  = NB_F21;
        cmd_o.cap     = 1'b1;
        cmd_o.cap_sel = NB_F11;
        state_d       = S_RD2;
      end
      S_RD2: begin
        cmd_o.rd      = 1'b1;
        cmd_o.rd_sel  = NB_F12;
        cmd_o.cap     = 1'b1;
        cmd_o.cap_sel = NB_F21;
        state_d       = S_RD3;
      end
      S_RD3: begin
        cmd_o.rd      = 1'b1;
        cmd_o.rd_sel  = NB_F22;
        cmd_o.cap     = 1'b1;
        cmd_o.cap_sel = NB_F12;
        state_d       = S_CAP;
      end
      S_CAP: begin
        cmd_o.cap     = 1'b1;
        cmd_o.cap_sel = NB_F22;
        state_d       = S_MULA;
      end
      S_MULA: begin
        cmd_o.mul_a = 1'b1;
        state_d     = S_MULB;
      end
      S_MULB: begin
        cmd_o.mul_b = 1'b1;
        state_d     = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef SYNTHESIS
  a_rd_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.rd |-> status_i.in_image)
    else $error("memory read issued for an outside query");

  a_outside_short: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RD0) && !status_i.in_image |=> (state_q == S_OUT))
    else $error("outside query did not go straight to the result");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |-> !cmd_o.load_out)
    else $error("result register loaded while a word still waits");

  a_mul_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CAP) |=> (state_q == S_MULA) ##1 (state_q == S_MULB)
      ##1 (state_q == S_OUT))
    else $error("multiply stages out of order");
`endif
endmodule
`default_nettype wire

@@ sv/bis_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
module bis_datapath #(
  parameter int MAX_ROWS   = 64,
  parameter int MAX_COLS   = 64,
  parameter int PIXEL_BITS = 16,
  parameter int FRAC_BITS  = 8
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  bis_pkg::bis_cmd_t                    cmd_i,
  output bis_pkg::bis_status_t                 status_o,
  input  logic                                 cfg_we_i,
  input  logic [bis_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [bis_pkg::COUNT_W-1:0]          cfg_wdata_i,
  input  logic [bis_pkg::INDEX_W-1:0]          pixel_row_i,
  input  logic [bis_pkg::INDEX_W-1:0]          pixel_col_i,
  input  logic [bis_pkg::PIXIN_W-1:0]          pixel_value_i,
  input  logic signed [bis_pkg::COORD_W-1:0]   query_row_i,
  input  logic signed [bis_pkg::COORD_W-1:0]   query_col_i,
  output logic                                 inside_res_o,
  output logic [bis_pkg::SAMPLE_W-1:0]         sample_o
);
  import bis_pkg::*;

  localparam int ROW_W  = $clog2(MAX_ROWS);
  localparam int COL_W  = $clog2(MAX_COLS);
  localparam int DEPTH  = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int LW     = (COUNT_W + FRAC_BITS > COORD_W) ? COUNT_W + FRAC_BITS : COORD_W;
  localparam int DW     = FRAC_BITS + 1;
  localparam int TW     = PIXEL_BITS + 2 * FRAC_BITS + 6;
  localparam int QW     = TW - 2 * FRAC_BITS;
  localparam logic [PIXEL_BITS-1:0] PIX_MAX = '1;

  // Configuration.
  logic [COUNT_W-1:0] rows_q, cols_q;
  logic [COUNT_W-1:0] h, w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= COUNT_RESET;
      cols_q <= COUNT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ROWS_IN_USE: rows_q <= cfg_wdata_i;
        REG_COLS_IN_USE: cols_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    h = rows_q;
    if (rows_q < COUNT_MIN) begin
      h = COUNT_MIN;
    end else if (32'(rows_q) > MAX_ROWS) begin
      h = COUNT_W'(MAX_ROWS);
    end
    w = cols_q;
    if (cols_q < COUNT_MIN) begin
      w = COUNT_MIN;
    end else if (32'(cols_q) > MAX_COLS) begin
      w = COUNT_W'(MAX_COLS);
    end
  end

  // Captured input word.
  logic [INDEX_W-1:0]        prow_q, pcol_q;
  logic [PIXIN_W-1:0]        pval_q;
  logic signed [COORD_W-1:0] qrow_q, qcol_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      prow_q <= pixel_row_i;
      pcol_q <= pixel_col_i;
      pval_q <= pixel_value_i;
      qrow_q <= query_row_i;
      qcol_q <= query_col_i;
    end
  end

  // Floor cell, fraction weights and the inside test.
  logic [LW-1:0]    xe, ye, hlim, wlim, ifl, jfl;
  logic             row_step, col_step, inside_d;
  logic [ROW_W-1:0] i1_q;
  logic [COL_W-1:0] j1_q;
  logic [DW-1:0]    dx_q, dy_q;
  logic             inside_q;

  assign xe   = LW'(qrow_q[COORD_W-2:0]);
  assign ye   = LW'(qcol_q[COORD_W-2:0]);
  assign hlim = LW'(h) << FRAC_BITS;
  assign wlim = LW'(w) << FRAC_BITS;
  assign ifl  = xe >> FRAC_BITS;
  assign jfl  = ye >> FRAC_BITS;
  // At the last row or column the cell steps back, so the weight is raised by one.
  assign row_step = (ifl == (LW'(h) - LW'(1)));
  assign col_step = (jfl == (LW'(w) - LW'(1)));
  assign inside_d = !qrow_q[COORD_W-1] && !qcol_q[COORD_W-1] && (xe < hlim) && (ye < wlim);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inside_q <= 1'b0;
    end else if (cmd_i.prep) begin
      inside_q <= inside_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.prep) begin
      i1_q <= ifl[ROW_W-1:0] - ROW_W'(row_step);
      j1_q <= jfl[COL_W-1:0] - COL_W'(col_step);
      dx_q <= {row_step, qrow_q[FRAC_BITS-1:0]};
      dy_q <= {col_step, qcol_q[FRAC_BITS-1:0]};
    end
  end

  // Image memory addressing.
  logic [ADDR_W-1:0]     base_addr, rd_addr, wr_addr, mem_addr;
  logic [PIXEL_BITS-1:0] mem_rdata;
  logic                  wr_ok;

  assign base_addr = ADDR_W'(32'(i1_q) * MAX_COLS + 32'(j1_q));
  assign wr_addr   = ADDR_W'(32'(prow_q) * MAX_COLS + 32'(pcol_q));
  assign wr_ok     = (32'(prow_q) < MAX_ROWS) && (32'(pcol_q) < MAX_COLS);

  always_comb begin
    unique case (cmd_i.rd_sel)
      NB_F11: rd_addr = base_addr;
      NB_F21: rd_addr = base_addr + ADDR_W'(MAX_COLS);
      NB_F12: rd_addr = base_addr + ADDR_W'(1);
      NB_F22: rd_addr = base_addr + ADDR_W'(MAX_COLS + 1);
      default: rd_addr = base_addr;
    endcase
  end

  assign mem_addr = cmd_i.wr ? wr_addr : rd_addr;

  bis_ram #(
    .WIDTH (PIXEL_BITS),
    .DEPTH (DEPTH)
  ) u_image (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr),
    .addr_i  (mem_addr),
    .wdata_i (PIXEL_BITS'(pval_q)),
    .rdata_o (mem_rdata)
  );

  assign status_o.wr_ok    = wr_ok;
  assign status_o.in_image = inside_q;

  // Neighbor registers.
  logic [PIXEL_BITS-1:0] f11_q, f21_q, f12_q, f22_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      case (cmd_i.cap_sel)
        NB_F11: f11_q <= mem_rdata;
        NB_F21: f21_q <= mem_rdata;
        NB_F12: f12_q <= mem_rdata;
        default: f22_q <= mem_rdata;
      endcase
    end
  end

  // First multiply stage: edge terms and the cross weight.
  logic signed [PIXEL_BITS:0]             d21, d12;
  logic signed [PIXEL_BITS+2:0]           dsum_d, dsum_q;
  logic signed [PIXEL_BITS+FRAC_BITS+2:0] p1_d, p2_d, p1_q, p2_q;
  logic [2*FRAC_BITS+1:0]                 pxy_d, pxy_q;

  assign d21    = $signed({1'b0, f21_q}) - $signed({1'b0, f11_q});
  assign d12    = $signed({1'b0, f12_q}) - $signed({1'b0, f11_q});
  assign dsum_d = $signed({3'b000, f11_q}) + $signed({3'b000, f22_q})
                - $signed({3'b000, f21_q}) - $signed({3'b000, f12_q});
  assign p1_d   = d21 * $signed({1'b0, dx_q});
  assign p2_d   = d12 * $signed({1'b0, dy_q});
  assign pxy_d  = dx_q * dy_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_a) begin
      p1_q   <= p1_d;
      p2_q   <= p2_d;
      pxy_q  <= pxy_d;
      dsum_q <= dsum_d;
    end
  end

  // Second stage: cross term and the partial sum, both scaled by 2^(2*FRAC_BITS).
  logic signed [TW-1:0] p3_d, p3_q, s_d, s_q, total;

  assign p3_d = dsum_q * $signed({1'b0, pxy_q});
  assign s_d  = ($signed(TW'(f11_q)) <<< (2 * FRAC_BITS))
              + (($signed(TW'(p1_q)) + $signed(TW'(p2_q))) <<< FRAC_BITS);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_b) begin
      p3_q <= p3_d;
      s_q  <= s_d;
    end
  end

  // Final sum, truncation and saturation to the pixel range.
  logic [QW-1:0]         qv;
  logic [PIXEL_BITS-1:0] res_pix;

  assign total = s_q + p3_q;
  assign qv    = total[TW-1:2*FRAC_BITS];

  always_comb begin
    if (total[TW-1]) begin
      res_pix = '0;
    end else if (qv > QW'(PIX_MAX)) begin
      res_pix = PIX_MAX;
    end else begin
      res_pix = qv[PIXEL_BITS-1:0];
    end
  end

  logic                out_inside_q;
  logic [SAMPLE_W-1:0] out_sample_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_inside_q <= inside_q;
      out_sample_q <= inside_q ? SAMPLE_W'(res_pix) : '0;
    end
  end

  assign inside_res_o = out_inside_q;
  assign sample_o     = out_sample_q;

`ifndef SYNTHESIS
  a_rd_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rd |-> (32'(rd_addr) < DEPTH))
    else $error("neighbor read beyond the image store");

  a_cell_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rd |-> ((32'(i1_q) + 1 < 32'(h)) && (32'(j1_q) + 1 < 32'(w))))
    else $error("floor cell lies outside the rows or columns in use");

  a_outside_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out && !inside_q |=> (!inside_res_o && (sample_o == '0)))
    else $error("outside query gave a nonzero result");
`endif
endmodule
`default_nettype wire

@@ sv/bilinear_image_sampler.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Bilinear image sampler.
// Input words arrive on req_i (valid/ready). func selects a pixel write or a
// sample query; a write returns no word, a query returns one word on rsp_o
// with inside_res and the interpolated sample (zero when outside).
// rows_in_use and cols_in_use are set through cfg_we_i/cfg_idx_i/cfg_wdata_i.
// Write them only while no word is in flight; the block does not enforce it.
// A write passes through a write state and returns to idle. A query inside
// the image goes from acceptance to a valid result word through these steps:
// the cell and weights, four serial reads of the single-port image memory
// with a registered read, two multiply stages and the final sum. A query
// outside the image goes from the cell test straight to the result. One
// word is in work at a time and the controller returns to idle after each,
// so a new word is not accepted before the last one is through.
// The result sits in an output register; the next word is accepted while it
// waits. If the receiver stalls, a finished query holds in the final stage
// until the output register frees up, and input stays stalled meanwhile.
// Reset sets both counts to 64 and empties the pipeline; pixel contents are
// undefined until written.
module bilinear_image_sampler #(
  parameter int MAX_ROWS   = 64,
  parameter int MAX_COLS   = 64,
  parameter int PIXEL_BITS = 16,
  parameter int FRAC_BITS  = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  bis_req_if.sink                       req_i,
  bis_rsp_if.source                     rsp_o,
  input  logic                          cfg_we_i,
  input  logic [bis_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [bis_pkg::COUNT_W-1:0]   cfg_wdata_i
);
  import bis_pkg::*;

  bis_cmd_t    cmd;
  bis_status_t status;

  bis_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_func_i   (req_i.func),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  bis_datapath #(
    .MAX_ROWS   (MAX_ROWS),
    .MAX_COLS   (MAX_COLS),
    .PIXEL_BITS (PIXEL_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .pixel_row_i   (req_i.pixel_row),
    .pixel_col_i   (req_i.pixel_col),
    .pixel_value_i (req_i.pixel_value),
    .query_row_i   (req_i.query_row),
    .query_col_i   (req_i.query_col),
    .inside_res_o  (rsp_o.inside_res),
    .sample_o      (rsp_o.sample)
  );
endmodule
`default_nettype wire
